// ----- rtl/dts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;

    localparam int OP_W    = 3;
    localparam int SLOT_W  = 4;
    localparam int DELAY_W = 32;
    localparam int KIND_W  = 2;
    localparam int TIME_W  = 48;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_SCHED_ONE = 3'd1,
        OP_SCHED_PER = 3'd2,
        OP_CANCEL    = 3'd3,
        OP_STOP      = 3'd4
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_IDLE   = 2'd3
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic now_inc;
        logic round_clr;
        logic scan_init;
        logic scan_step;
        logic iv_rd;
        logic fire;
        logic exec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic              is_tick;
        logic              scan_done;
        logic              best_vld;
        logic              rounds_left;
        t_kind             res_kind;
        logic [SLOT_W-1:0] res_slot;
        logic [SLOT_W-1:0] best_slot;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/dts_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface dts_in_if;
    import dts_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [SLOT_W-1:0]   slot;
    logic [DELAY_W-1:0]  delay;
    logic                run_now;

    modport source (output valid, opcode, slot, delay, run_now, input ready);
    modport sink   (input valid, opcode, slot, delay, run_now, output ready);
endinterface
`default_nettype wire

// ----- rtl/dts_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface dts_out_if;
    import dts_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot_res;
    logic                last;

    modport source (output valid, kind, slot_res, last, input ready);
    modport sink   (input valid, kind, slot_res, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/dts_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dts_datapath #(
    parameter int SLOTS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [dts_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [dts_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [dts_pkg::DELAY_W-1:0] i_delay,
    input  wire logic                        i_run_now,
    input  wire dts_pkg::t_cmd               i_cmd,
    output dts_pkg::t_sts                    o_sts
);
    import dts_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int RW = $clog2(SLOTS + 1);

    // latched item
    logic [OP_W-1:0]    r_op;
    logic [SLOT_W-1:0]  r_slot;
    logic [DELAY_W-1:0] r_delay;
    logic               r_run_now;

    logic [TIME_W-1:0]  r_now;
    logic               r_stopped;
    logic [SLOTS-1:0]   r_armed;

    // slot tables
    logic [TIME_W-1:0]  r_dl_mem [SLOTS];
    logic [DELAY_W-1:0] r_iv_mem [SLOTS];

    // scan state
    logic [IW:0]        r_scan_idx;
    logic               r_rd_pend;
    logic [IW-1:0]      r_rd_idx;
    logic [TIME_W-1:0]  r_rd_dl;
    logic               r_best_vld;
    logic [IW-1:0]      r_best_idx;
    logic [TIME_W-1:0]  r_best_dl;
    logic [DELAY_W-1:0] r_iv;
    logic [RW-1:0]      r_round;

    logic               in_range;
    logic [IW-1:0]      slot_ix;
    logic               sched_ok;
    logic               is_sched;
    logic               scan_more;
    logic               cand;
    logic [TIME_W-1:0]  now_plus_delay;
    logic [TIME_W-1:0]  now_plus_iv;
    logic               dl_we;
    logic [IW-1:0]      dl_waddr;
    logic [TIME_W-1:0]  dl_wdata;
    logic               iv_we;
    logic [DELAY_W-1:0] iv_wdata;
    t_kind              res_kind;
    logic [SLOT_W-1:0]  res_slot;

    assign in_range       = 32'(r_slot) < 32'(SLOTS);
    assign slot_ix        = IW'(r_slot);
    assign is_sched       = (r_op == OP_SCHED_ONE) || (r_op == OP_SCHED_PER);
    assign sched_ok       = in_range && !r_stopped && !r_armed[slot_ix];
    assign scan_more      = r_scan_idx != (IW+1)'(SLOTS);
    assign now_plus_delay = r_now + TIME_W'(r_delay);
    assign now_plus_iv    = r_now + TIME_W'(r_iv);
    assign cand = r_rd_pend && r_armed[r_rd_idx] && (r_rd_dl <= r_now)
                  && (!r_best_vld || (r_rd_dl < r_best_dl));

    // table write port
    always_comb begin
        dl_we    = 1'b0;
        dl_waddr = r_best_idx;
        dl_wdata = now_plus_iv;
        iv_we    = 1'b0;
        iv_wdata = r_delay;
        if (i_cmd.exec && is_sched && sched_ok) begin
            dl_we    = 1'b1;
            dl_waddr = slot_ix;
            iv_we    = 1'b1;
            if (r_op == OP_SCHED_ONE) begin
                dl_wdata = now_plus_delay;
                iv_wdata = '0;
            end else begin
                dl_wdata = r_run_now ? r_now : now_plus_delay;
            end
        end else if (i_cmd.fire && (r_iv != '0)) begin
            dl_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            r_dl_mem[dl_waddr] <= dl_wdata;
        end
        if (iv_we) begin
            r_iv_mem[slot_ix] <= iv_wdata;
        end
        if (i_cmd.scan_step && scan_more) begin
            r_rd_dl <= r_dl_mem[r_scan_idx[IW-1:0]];
        end
        if (i_cmd.iv_rd) begin
            r_iv <= r_iv_mem[r_best_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op      <= i_opcode;
            r_slot    <= i_slot;
            r_delay   <= i_delay;
            r_run_now <= i_run_now;
        end
        if (i_cmd.scan_step && scan_more) begin
            r_rd_idx <= r_scan_idx[IW-1:0];
        end
        if (i_cmd.scan_step && cand) begin
            r_best_idx <= r_rd_idx;
            r_best_dl  <= r_rd_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_stopped  <= 1'b0;
            r_armed    <= '0;
            r_scan_idx <= '0;
            r_rd_pend  <= 1'b0;
            r_best_vld <= 1'b0;
            r_round    <= '0;
        end else begin
            if (i_cmd.now_inc) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (i_cmd.round_clr) begin
                r_round <= '0;
            end
            if (i_cmd.scan_init) begin
                r_scan_idx <= '0;
                r_rd_pend  <= 1'b0;
                r_best_vld <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_rd_pend <= scan_more;
                if (scan_more) begin
                    r_scan_idx <= r_scan_idx + (IW+1)'(1);
                end
                if (cand) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (i_cmd.fire) begin
                r_round <= r_round + RW'(1);
                if (r_iv == '0) begin
                    r_armed[r_best_idx] <= 1'b0;
                end
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_SCHED_ONE, OP_SCHED_PER: begin
                        if (sched_ok) begin
                            r_armed[slot_ix] <= 1'b1;
                        end
                    end
                    OP_CANCEL: begin
                        if (in_range) begin
                            r_armed[slot_ix] <= 1'b0;
                        end
                    end
                    OP_STOP: begin
                        r_armed   <= '0;
                        r_stopped <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result of a non-tick item
    always_comb begin
        res_kind = KIND_REJECT;
        res_slot = r_slot;
        case (r_op)
            OP_SCHED_ONE, OP_SCHED_PER: begin
                res_kind = sched_ok ? KIND_ACCEPT : KIND_REJECT;
            end
            OP_CANCEL: begin
                res_kind = in_range ? KIND_ACCEPT : KIND_REJECT;
            end
            OP_STOP: begin
                res_kind = KIND_ACCEPT;
                res_slot = '0;
            end
            default: begin
                res_slot = '0;
            end
        endcase
    end

    assign o_sts.res_kind    = res_kind;
    assign o_sts.res_slot    = res_slot;
    assign o_sts.is_tick     = r_op == OP_TICK;
    assign o_sts.scan_done   = !scan_more && !r_rd_pend;
    assign o_sts.best_vld    = r_best_vld;
    assign o_sts.rounds_left = r_round != RW'(SLOTS);
    assign o_sts.best_slot   = SLOT_W'(r_best_idx);

endmodule
`default_nettype wire

// ----- rtl/dts_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dts_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [dts_pkg::KIND_W-1:0]      o_kind,
    output logic [dts_pkg::SLOT_W-1:0]      o_slot_res,
    output logic                            o_last,
    output dts_pkg::t_cmd                   o_cmd,
    input  wire dts_pkg::t_sts              i_sts
);
    import dts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_SCAN_INIT,
        S_SCAN,
        S_FIRE_RD,
        S_FIRE,
        S_EMIT_IDLE
    } t_state;

    t_state            r_state, n_state;
    logic              r_out_valid;
    t_kind             r_kind, n_kind;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_last, n_last;
    logic              out_free;
    logic              out_load;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        out_load = 1'b0;
        n_kind   = KIND_IDLE;
        n_slot   = '0;
        n_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_tick) begin
                    o_cmd.now_inc   = 1'b1;
                    o_cmd.round_clr = 1'b1;
                    n_state         = S_SCAN_INIT;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    out_load   = 1'b1;
                    n_kind     = i_sts.res_kind;
                    n_slot     = i_sts.res_slot;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.best_vld && i_sts.rounds_left) begin
                        n_state = S_FIRE_RD;
                    end else begin
                        n_state = S_EMIT_IDLE;
                    end
                end
            end
            S_FIRE_RD: begin
                o_cmd.iv_rd = 1'b1;
                n_state     = S_FIRE;
            end
            S_FIRE: begin
                if (out_free) begin
                    o_cmd.fire = 1'b1;
                    out_load   = 1'b1;
                    n_kind     = KIND_FIRED;
                    n_slot     = i_sts.best_slot;
                    n_last     = 1'b0;
                    n_state    = S_SCAN_INIT;
                end
            end
            S_EMIT_IDLE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_kind      <= n_kind;
                r_slot      <= n_slot;
                r_last      <= n_last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_slot_res  = r_slot;
    assign o_last      = r_last;

endmodule
`default_nettype wire

// ----- rtl/deadline_timer_scheduler.sv -----
// deadline timer scheduler: SLOTS timer slots, each armed with a 48-bit deadline in ticks
// i_req carries one request word: tick, schedule one-shot, schedule periodic, cancel, stop
// o_rsp returns result words; each request ends with a word that has last set
// schedule, cancel, stop and unknown opcodes give one word (accepted or rejected)
// a tick advances the time by one, then gives one fired word per due slot in deadline
// order (ties to the lower slot), then a nothing-more-due word with slot 0
// a non-tick request goes through decode, then exec, which loads its result word
// a tick costs one scan of the deadline table per fired slot plus a final scan;
// each scan reads the table one slot a cycle through its single read port, and each
// fired slot then reads its interval in S_FIRE_RD and loads its word in S_FIRE
// one request is in work at a time; i_req.ready is high only while idle
// the result word sits in an output register, so the next request is taken
// while the last word of the previous one still waits for o_rsp.ready
// a stalled receiver holds the block at its next result word, nothing is dropped
// reset (synchronous, active low) clears time, the armed flags and the stop flag;
// deadline and interval table entries are only used for armed slots and need no clearing
`timescale 1ns / 1ps
`default_nettype none
module deadline_timer_scheduler #(
    parameter int SLOTS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dts_in_if.sink     i_req,
    dts_out_if.source  o_rsp
);
    import dts_pkg::*;

    // command and status between the sequencer and the slot table datapath
    t_cmd cmd;
    t_sts sts;

    dts_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_opcode  (i_req.opcode),
        .i_slot    (i_req.slot),
        .i_delay   (i_req.delay),
        .i_run_now (i_req.run_now),
        .i_cmd     (cmd),
        .o_sts     (sts)
    );

    // sequencer also owns the output word register
    dts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_kind      (o_rsp.kind),
        .o_slot_res  (o_rsp.slot_res),
        .o_last      (o_rsp.last),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

endmodule
`default_nettype wire
